// ===== hw/rtl/slot_timer_scheduler_top_defines.svh =====
// Assertion macros for the slot timer scheduler.
`ifndef SLOT_TIMER_SCHEDULER_TOP_DEFINES_SVH
`define SLOT_TIMER_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/stts_pkg.sv =====
// Shared widths, opcodes and constants of the slot timer scheduler.
package stts_pkg;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int TIME_W = 32;
  localparam int MASK_W = 16;

  typedef logic [OP_W-1:0]   opcode_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam opcode_t OP_TICK     = 3'd0;
  localparam opcode_t OP_SET      = 3'd1;
  localparam opcode_t OP_READ     = 3'd2;
  localparam opcode_t OP_SCAN     = 3'd3;
  localparam opcode_t OP_CLR_WAKE = 3'd4;
  localparam opcode_t OP_CLR_DUE  = 3'd5;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOR = 1'b1;

  localparam time_t TIME_ALL_ONES = '1;

endpackage

// ===== hw/rtl/stts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stts_ram
  #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
  )
  (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/stts_cmp.sv =====
// Shared 32-bit magnitude comparator used by the tick, set and scan steps.
module stts_cmp
  import stts_pkg::*;
  (
  input  time_t a,
  input  time_t b,
  output logic  lt
  );

  // Unsigned a < b; the callers derive <= and > by swapping and inverting.
  assign lt = (a < b);

endmodule

// ===== hw/rtl/slot_timer_scheduler_top.sv =====
// Slot timer scheduler: slot table, tick counter and the command sequencer.
//
// One command is taken when start is high and busy is low; busy then stays
// high until the cycle that strobes the result word, so the next command may
// be taken while that word is on the ports. The result appears on the out_
// ports for exactly one cycle with out_valid high and cannot be held off.
// Tick, set with arming and read pass through their working state (S_TICK,
// S_SET, S_READ) and then S_RESP before the strobe; set with disarming,
// out-of-range accesses, both clear commands, unused opcodes and a scan
// with nothing armed go straight to S_RESP. A scan visits every slot
// and then S_RESP, one slot per cycle but for a second step (S_SCAN_LT)
// for each armed slot not yet due: the slot table has one read port, and
// such a slot needs the one shared comparator twice (due test, then the
// running minimum). The slot table is a RAM; an entry that was never
// written reads as zero through a per-slot valid bit cleared at reset, so
// no clearing pass is needed. Commands take effect in order: the result
// word reports the state after the command.
module slot_timer_scheduler_top
  import stts_pkg::*;
  #(
  parameter int SLOT_COUNT = 16
  )
  (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [IDX_W-1:0]  in_slot_index,
  input  logic [TIME_W-1:0] in_trigger_time,
  input  logic              in_enable,
  output logic              out_valid,
  output logic              out_status,
  output logic [TIME_W-1:0] out_read_time,
  output logic              out_read_enabled,
  output logic [TIME_W-1:0] out_time_now,
  output logic [TIME_W-1:0] out_next_due,
  output logic              out_wake_flag,
  output logic [MASK_W-1:0] out_due_mask
  );

`include "slot_timer_scheduler_top_defines.svh"

  // Slot address width; a single slot still gets one address bit.
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W:0] SLOT_LIM = (IDX_W + 1)'(SLOT_COUNT);
  localparam logic [IW-1:0]  LAST_IDX = IW'(SLOT_COUNT - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TICK    = 3'd1;
  localparam logic [2:0] S_SET     = 3'd2;
  localparam logic [2:0] S_READ    = 3'd3;
  localparam logic [2:0] S_SCAN_LE = 3'd4;
  localparam logic [2:0] S_SCAN_LT = 3'd5;
  localparam logic [2:0] S_RESP    = 3'd6;

  logic [2:0]            state_r, state_nxt;

  // Architectural state.
  time_t                 tick_r, tick_nxt;
  time_t                 due_r, due_nxt;
  logic                  wake_r, wake_nxt;
  logic [SLOT_COUNT-1:0] armed_r, armed_nxt;
  logic [SLOT_COUNT-1:0] fired_r, fired_nxt;
  logic [SLOT_COUNT-1:0] vld_r, vld_nxt;

  // Latched command word and per-command working registers.
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  time_t                 trig_r, trig_nxt;
  logic [IW-1:0]         sidx_r, sidx_nxt;
  time_t                 best_r, best_nxt;
  logic                  stat_r, stat_nxt;
  time_t                 rtime_r, rtime_nxt;
  logic                  ren_r, ren_nxt;

  // Result word registers.
  logic                  out_valid_r;
  logic                  out_status_r;
  time_t                 out_read_time_r;
  logic                  out_read_enabled_r;
  time_t                 out_time_now_r;
  time_t                 out_next_due_r;
  logic                  out_wake_flag_r;
  logic [MASK_W-1:0]     out_due_mask_r;

  // Slot table port and shared comparator.
  logic                  ram_we;
  logic [IW-1:0]         ram_raddr;
  time_t                 ram_rdata;
  logic [IW-1:0]         ridx;
  time_t                 slot_data;
  time_t                 cmp_a, cmp_b;
  logic                  cmp_lt;
  logic                  idx_oor;
  logic                  scan_step;

  stts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SLOT_COUNT),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_slot_index[IW-1:0]),
    .wdata (in_trigger_time),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stts_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt)
  );

  assign idx_oor = ({1'b0, in_slot_index} >= SLOT_LIM);

  // Slot whose data sits on the RAM output this cycle; mask unwritten entries.
  assign ridx      = (state_r == S_READ) ? idx_r[IW-1:0] : sidx_r;
  assign slot_data = vld_r[ridx] ? ram_rdata : '0;

  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    due_nxt   = due_r;
    wake_nxt  = wake_r;
    armed_nxt = armed_r;
    fired_nxt = fired_r;
    vld_nxt   = vld_r;
    idx_nxt   = idx_r;
    trig_nxt  = trig_r;
    sidx_nxt  = sidx_r;
    best_nxt  = best_r;
    stat_nxt  = stat_r;
    rtime_nxt = rtime_r;
    ren_nxt   = ren_r;
    ram_we    = 1'b0;
    cmp_a     = '0;
    cmp_b     = '0;
    scan_step = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt   = in_slot_index;
          trig_nxt  = in_trigger_time;
          stat_nxt  = STATUS_OK;
          rtime_nxt = '0;
          ren_nxt   = 1'b0;
          state_nxt = S_RESP;
          unique case (in_opcode)
            OP_TICK: begin
              // Advance time now; the due test follows on the comparator.
              tick_nxt  = tick_r + 1'b1;
              state_nxt = S_TICK;
            end
            OP_SET: begin
              if (idx_oor) begin
                stat_nxt = STATUS_OOR;
              end else begin
                ram_we                          = 1'b1;
                vld_nxt[in_slot_index[IW-1:0]]  = 1'b1;
                armed_nxt[in_slot_index[IW-1:0]] = in_enable;
                if (in_enable) begin
                  state_nxt = S_SET;
                end
              end
            end
            OP_READ: begin
              if (idx_oor) begin
                stat_nxt = STATUS_OOR;
              end else begin
                state_nxt = S_READ;
              end
            end
            OP_SCAN: begin
              // Nothing armed: leave next-due untouched.
              if (armed_r != '0) begin
                best_nxt  = TIME_ALL_ONES;
                sidx_nxt  = '0;
                state_nxt = S_SCAN_LE;
              end
            end
            OP_CLR_WAKE: wake_nxt = 1'b0;
            OP_CLR_DUE:  fired_nxt = '0;
            default: ;
          endcase
        end
      end
      S_TICK: begin
        // Wake once next-due <= time.
        cmp_a = tick_r;
        cmp_b = due_r;
        if (!cmp_lt) begin
          wake_nxt = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_SET: begin
        // Lower next-due to the new trigger if earlier.
        cmp_a = trig_r;
        cmp_b = due_r;
        if (cmp_lt) begin
          due_nxt = trig_r;
        end
        state_nxt = S_RESP;
      end
      S_READ: begin
        rtime_nxt = slot_data;
        ren_nxt   = armed_r[idx_r[IW-1:0]];
        state_nxt = S_RESP;
      end
      S_SCAN_LE: begin
        if (armed_r[sidx_r]) begin
          cmp_a = tick_r;
          cmp_b = slot_data;
          if (cmp_lt) begin
            // Still pending: fold into the minimum next cycle.
            state_nxt = S_SCAN_LT;
          end else begin
            armed_nxt[sidx_r] = 1'b0;
            fired_nxt[sidx_r] = 1'b1;
            scan_step         = 1'b1;
          end
        end else begin
          scan_step = 1'b1;
        end
      end
      S_SCAN_LT: begin
        cmp_a = slot_data;
        cmp_b = best_r;
        if (cmp_lt) begin
          best_nxt = slot_data;
        end
        scan_step = 1'b1;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Advance to the next slot, or commit the minimum after the last one.
    if (scan_step) begin
      if (sidx_r == LAST_IDX) begin
        due_nxt   = best_nxt;
        state_nxt = S_RESP;
      end else begin
        sidx_nxt  = sidx_r + 1'b1;
        state_nxt = S_SCAN_LE;
      end
    end
  end

  // Address the slot needed next cycle so its data is ready on arrival;
  // a scan starts from slot zero.
  assign ram_raddr = (state_r == S_IDLE && in_opcode != OP_SCAN) ?
                     in_slot_index[IW-1:0] : sidx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      due_r       <= TIME_ALL_ONES;
      wake_r      <= 1'b0;
      armed_r     <= '0;
      fired_r     <= '0;
      vld_r       <= '0;
      sidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      due_r       <= due_nxt;
      wake_r      <= wake_nxt;
      armed_r     <= armed_nxt;
      fired_r     <= fired_nxt;
      vld_r       <= vld_nxt;
      sidx_r      <= sidx_nxt;
      out_valid_r <= (state_r == S_RESP);
    end
  end

  // Payload registers: command word, working values and the result word.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    trig_r  <= trig_nxt;
    best_r  <= best_nxt;
    stat_r  <= stat_nxt;
    rtime_r <= rtime_nxt;
    ren_r   <= ren_nxt;
    if (state_r == S_RESP) begin
      out_status_r       <= stat_r;
      out_read_time_r    <= rtime_r;
      out_read_enabled_r <= ren_r;
      out_time_now_r     <= tick_r;
      out_next_due_r     <= due_r;
      out_wake_flag_r    <= wake_r;
      out_due_mask_r     <= MASK_W'(fired_r);
    end
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_time    = out_read_time_r;
  assign out_read_enabled = out_read_enabled_r;
  assign out_time_now     = out_time_now_r;
  assign out_next_due     = out_next_due_r;
  assign out_wake_flag    = out_wake_flag_r;
  assign out_due_mask     = out_due_mask_r;

  // A result word only ever follows a busy cycle.
  `STTS_ASSERT_NOW(a_strobe_after_busy, out_valid, $past(busy), "result strobe without a command")
  // An accepted command always makes the block busy.
  `STTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "command accepted but block idle")
  // One strobe per command: never two in a row.
  `STTS_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobed twice")
  // The scan index stays inside the slot table while scanning.
  `STTS_ASSERT_NOW(a_scan_idx, (state_r == S_SCAN_LE) || (state_r == S_SCAN_LT), sidx_r <= LAST_IDX, "scan index past last slot")

endmodule

// ===== test/slot_timer_scheduler_top_test.sv =====
// Self-checking testbench for the slot timer scheduler: directed and random commands.
module slot_timer_scheduler_top_test;
  import stts_pkg::*;

  localparam int SLOTS   = 16;
  localparam int SLOT_AW = $clog2(SLOTS);

  // Opcodes with no function; the block must answer them without a state change.
  localparam opcode_t OP_SPARE_A = 3'd6;
  localparam opcode_t OP_SPARE_B = 3'd7;

  // Longest command is a scan with every slot armed and pending.
  localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
  localparam int RANDOM_CMDS   = 1450;

  // One command as the sender sees it: fields plus the idle time ahead of it.
  typedef struct {
    opcode_t           op;
    logic [IDX_W-1:0]  idx;
    time_t             trig;
    logic              en;
    int unsigned       gap;
    bit                drain;
  } sched_cmd_t;

  // One result word, field by field.
  typedef struct {
    logic              status;
    time_t             read_time;
    logic              read_enabled;
    time_t             time_now;
    time_t             next_due;
    logic              wake_flag;
    logic [MASK_W-1:0] due_mask;
  } status_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_opcode = '0;
  logic [IDX_W-1:0]  in_slot_index = '0;
  logic [TIME_W-1:0] in_trigger_time = '0;
  logic              in_enable = 1'b0;
  logic              out_valid;
  logic              out_status;
  logic [TIME_W-1:0] out_read_time;
  logic              out_read_enabled;
  logic [TIME_W-1:0] out_time_now;
  logic [TIME_W-1:0] out_next_due;
  logic              out_wake_flag;
  logic [MASK_W-1:0] out_due_mask;

  slot_timer_scheduler_top #(.SLOT_COUNT(SLOTS)) DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scheduler state as the testbench tracks it, advanced once per accepted word.
  // ---------------------------------------------------------------------------
  time_t             mdl_slot_time [SLOTS];
  logic [MASK_W-1:0] mdl_armed;
  time_t             mdl_ticks;
  time_t             mdl_next_due;
  logic              mdl_wake;
  logic [MASK_W-1:0] mdl_fired;

  status_word_t      sched_words_q[$];   // result words still owed by the block
  sched_cmd_t        pending_cmds[$];    // commands not yet handed to the driver
  int                errors = 0;

  // Apply one command to the tracked state and return the word it must produce.
  function automatic status_word_t apply_command(opcode_t op, logic [IDX_W-1:0] idx,
                                                 time_t trig, logic en);
    status_word_t w;
    time_t        best;
    w = '{status: STATUS_OK, read_time: '0, read_enabled: 1'b0, time_now: '0,
          next_due: '0, wake_flag: 1'b0, due_mask: '0};
    case (op)
      OP_TICK: begin
        mdl_ticks = mdl_ticks + 1;
        if (mdl_next_due <= mdl_ticks) mdl_wake = 1'b1;
      end
      OP_SET: begin
        if (idx >= SLOTS) begin
          w.status = STATUS_OOR;
        end else begin
          mdl_slot_time[idx[SLOT_AW-1:0]] = trig;
          if (en) begin
            mdl_armed[idx[SLOT_AW-1:0]] = 1'b1;
            if (mdl_next_due > trig) mdl_next_due = trig;
          end else begin
            // Disarming never raises next-due; only a scan does that.
            mdl_armed[idx[SLOT_AW-1:0]] = 1'b0;
          end
        end
      end
      OP_READ: begin
        if (idx >= SLOTS) begin
          w.status = STATUS_OOR;
        end else begin
          w.read_time    = mdl_slot_time[idx[SLOT_AW-1:0]];
          w.read_enabled = mdl_armed[idx[SLOT_AW-1:0]];
        end
      end
      OP_SCAN: begin
        // Leave next-due alone when nothing is armed; otherwise retire due
        // slots and take the minimum over the ones still pending.
        if (mdl_armed != '0) begin
          best = TIME_ALL_ONES;
          for (int s = 0; s < SLOTS; s++) begin
            if (mdl_armed[s]) begin
              if (mdl_slot_time[s] <= mdl_ticks) begin
                mdl_armed[s] = 1'b0;
                mdl_fired[s] = 1'b1;
              end else if (mdl_slot_time[s] < best) begin
                best = mdl_slot_time[s];
              end
            end
          end
          mdl_next_due = best;
        end
      end
      OP_CLR_WAKE: mdl_wake = 1'b0;
      OP_CLR_DUE:  mdl_fired = '0;
      default: ;
    endcase
    w.time_now  = mdl_ticks;
    w.next_due  = mdl_next_due;
    w.wake_flag = mdl_wake;
    w.due_mask  = mdl_fired;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued commands, honor per-command gaps and drain points.
  // ---------------------------------------------------------------------------
  sched_cmd_t  cur_cmd;
  bit          holding = 1'b0;   // cur_cmd is loaded and not yet accepted
  int unsigned idle_left = 0;

  always @(posedge clk) begin : driver
    logic launch;
    logic accepted;
    logic drained;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      launch   = start;
      accepted = start && !busy;
      // At most one word is outstanding, so outside an accept edge the owed
      // queue holds zero or one entry; count a word strobed now as arrived.
      drained  = !accepted && (sched_words_q.size() == 0 ||
                               (sched_words_q.size() == 1 && out_valid));
      if (accepted) begin
        sched_words_q.push_back(apply_command(in_opcode, in_slot_index,
                                              in_trigger_time, in_enable));
        launch  = 1'b0;
        holding = 1'b0;
      end
      if (!launch) begin
        if (!holding && pending_cmds.size() != 0) begin
          cur_cmd   = pending_cmds.pop_front();
          holding   = 1'b1;
          idle_left = cur_cmd.gap;
        end
        if (holding) begin
          if (idle_left != 0) begin
            idle_left--;
          end else if (!cur_cmd.drain || drained) begin
            in_opcode       <= cur_cmd.op;
            in_slot_index   <= cur_cmd.idx;
            in_trigger_time <= cur_cmd.trig;
            in_enable       <= cur_cmd.en;
            launch = 1'b1;
          end
        end
      end
      // Single update per edge: start stays high straight through back-to-back words.
      start <= launch;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed word must match the oldest owed word.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    status_word_t want;
    if (rst_n && out_valid) begin
      if (sched_words_q.size() == 0) begin
        $display("%0t: result word with none owed, expected nothing, got time_now 0x%0h",
                 $time, out_time_now);
        errors++;
      end else begin
        want = sched_words_q.pop_front();
        check_field("status", TIME_W'(want.status), TIME_W'(out_status));
        check_field("read_time", want.read_time, out_read_time);
        check_field("read_enabled", TIME_W'(want.read_enabled), TIME_W'(out_read_enabled));
        check_field("time_now", want.time_now, out_time_now);
        check_field("next_due", want.next_due, out_next_due);
        check_field("wake_flag", TIME_W'(want.wake_flag), TIME_W'(out_wake_flag));
        check_field("due_mask", TIME_W'(want.due_mask), TIME_W'(out_due_mask));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------
  time_t gen_ticks = '0;     // tick count the block will have reached so far
  bit    quiet_run = 1'b0;   // hold the sender gap-free for a stretch

  // Queue a command with a random lead gap: mostly none, some short, a few long.
  task automatic queue_cmd(opcode_t op, int idx, time_t trig, logic en, bit drain = 1'b0);
    sched_cmd_t  c;
    int unsigned r;
    r       = $urandom_range(0, 99);
    c.op    = op;
    c.idx   = idx[IDX_W-1:0];
    c.trig  = trig;
    c.en    = en;
    c.drain = drain;
    if (quiet_run || r < 60) c.gap = 0;
    else if (r < 94)         c.gap = $urandom_range(1, 6);
    else                     c.gap = $urandom_range(7, 45);
    if (op == OP_TICK) gen_ticks = gen_ticks + 1;
    pending_cmds.push_back(c);
  endtask

  // Bias trigger times around the current tick so slots actually come due.
  function automatic time_t pick_trigger();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return gen_ticks + $urandom_range(0, 24);
    if (r < 75) return gen_ticks - $urandom_range(0, 12);
    if (r < 90) return $urandom();
    if (r < 95) return TIME_ALL_ONES;
    return '0;
  endfunction

  function automatic int pick_slot();
    if ($urandom_range(0, 9) == 0) return $urandom_range(SLOTS, 31);
    return $urandom_range(0, SLOTS - 1);
  endfunction

  initial begin : stimulus
    int unsigned r;
    int          idx;
    time_t       trig;
    logic        en;
    bit          drain;

    foreach (mdl_slot_time[s]) mdl_slot_time[s] = '0;
    mdl_armed    = '0;
    mdl_ticks    = '0;
    mdl_next_due = TIME_ALL_ONES;
    mdl_wake     = 1'b0;
    mdl_fired    = '0;

    // Directed walk through the corner cases.
    queue_cmd(OP_READ, 0, '0, 1'b0);              // never-written slot reads zero
    queue_cmd(OP_READ, 31, TIME_ALL_ONES, 1'b1);  // read out of range
    queue_cmd(OP_SET, 20, 32'd123, 1'b1);         // set out of range, no effect
    queue_cmd(OP_SET, 15, TIME_ALL_ONES, 1'b1);   // arm at all ones: next-due holds
    queue_cmd(OP_SET, 0, 32'd2, 1'b1);            // lowers next-due
    queue_cmd(OP_SET, 1, 32'd5, 1'b1);
    queue_cmd(OP_SET, 2, 32'd3, 1'b0);            // written but disarmed
    queue_cmd(OP_TICK, 0, '0, 1'b0);
    queue_cmd(OP_TICK, 0, '0, 1'b0);              // reaches next-due: wake
    queue_cmd(OP_SCAN, 0, '0, 1'b0);              // slot 0 fires
    queue_cmd(OP_CLR_WAKE, 0, '0, 1'b0);
    queue_cmd(OP_READ, 0, '0, 1'b0);
    repeat (3) queue_cmd(OP_TICK, 0, '0, 1'b0);
    queue_cmd(OP_SCAN, 0, '0, 1'b0);              // slot 1 fires, slot 15 left at all ones
    queue_cmd(OP_SET, 15, '0, 1'b0);              // disarm: next-due unchanged
    queue_cmd(OP_SCAN, 0, '0, 1'b0);              // nothing armed
    queue_cmd(OP_CLR_DUE, 0, '0, 1'b0);
    queue_cmd(OP_SPARE_A, 31, TIME_ALL_ONES, 1'b1);
    queue_cmd(OP_SPARE_B, 17, 32'h5A5A_A5A5, 1'b0);
    queue_cmd(OP_SET, 3, '0, 1'b1);
    queue_cmd(OP_SET, 4, 32'd7, 1'b1);
    queue_cmd(OP_TICK, 0, '0, 1'b0);
    queue_cmd(OP_SCAN, 0, '0, 1'b0);              // slot 3 fires, slot 4 pending
    queue_cmd(OP_TICK, 0, '0, 1'b0);
    queue_cmd(OP_SCAN, 0, '0, 1'b0);              // every armed slot fires

    // Random traffic in stretches, some of them gap-free, with a few drain points.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 120 == 0) quiet_run = ($urandom_range(0, 3) == 0);
      drain = (n % 350 == 0);
      r     = $urandom_range(0, 99);
      idx   = pick_slot();
      trig  = $urandom();
      en    = 1'($urandom_range(0, 1));
      if (r < 28) begin
        queue_cmd(OP_TICK, idx, trig, en, drain);
      end else if (r < 52) begin
        en = ($urandom_range(0, 3) != 0);
        queue_cmd(OP_SET, idx, pick_trigger(), en, drain);
      end else if (r < 64) begin
        queue_cmd(OP_READ, idx, trig, en, drain);
      end else if (r < 80) begin
        queue_cmd(OP_SCAN, idx, trig, en, drain);
      end else if (r < 87) begin
        queue_cmd(OP_CLR_WAKE, idx, trig, en, drain);
      end else if (r < 94) begin
        queue_cmd(OP_CLR_DUE, idx, trig, en, drain);
      end else begin
        queue_cmd(r[0] ? OP_SPARE_A : OP_SPARE_B, $urandom_range(0, 31), trig, en, drain);
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the sender to empty and every owed word to arrive, then settle.
    do @(negedge clk);
    while (pending_cmds.size() != 0 || holding || start || sched_words_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("** slot_timer_scheduler_top: PASSED **");
    end else begin
      $display("** slot_timer_scheduler_top: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("** slot_timer_scheduler_top: FAILED **");
    $finish;
  end

endmodule
